[sv/pets_pkg.sv]
// Package for the periodic event tick scheduler: widths, codes and reset values.
// No dependencies; imported by the scheduler top level and its checker.
`default_nettype none

package pets_pkg;

    // Scheduler channel count (1 to 8). Only the first PERIOD_REGS have writable
    // periods; only the first MASK_W have deferred bits and result mask bits.
    localparam int CHANNELS   = 4;

    localparam int TICK_W     = 16;
    localparam int PERIOD_W   = 15;
    localparam int MASK_W     = 4;
    localparam int PERIOD_REGS = 4;
    localparam int OP_W       = 2;
    localparam int CH_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);

    typedef logic [TICK_W-1:0]   t_tick;
    typedef logic [PERIOD_W-1:0] t_period;
    typedef logic [MASK_W-1:0]   t_mask;

    typedef enum logic [OP_W-1:0] {
        OP_TICK       = 2'd0,
        OP_SERVICE    = 2'd1,
        OP_SET_ENABLE = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD_CH0 = 3'd0,
        CFG_PERIOD_CH1 = 3'd1,
        CFG_PERIOD_CH2 = 3'd2,
        CFG_PERIOD_CH3 = 3'd3,
        CFG_DEFERRED   = 3'd4,
        CFG_RUN        = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

[sv/periodic_event_tick_scheduler.sv]
// Periodic event tick scheduler top level; depends on pets_pkg.
// Transactions pass the input register, then the result register; throughput is one per
// cycle, set by the single-pass compare of all channels, unless the result side stalls.
// A waiting result holds; one more transaction enters an empty input register meanwhile.
// Reset (synchronous, active low) clears the tick counter, channel state, pending flags,
// run enable and deferred mask, and returns every period register to 1000.
`default_nettype none

module periodic_event_tick_scheduler
    import pets_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic [OP_W-1:0]       i_op,
    input  wire logic [CH_W-1:0]       i_channel,
    input  wire logic                  i_enable_value,
    // result channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output logic [MASK_W-1:0]          o_fired_mask,
    output logic [MASK_W-1:0]          o_serviced_mask,
    output logic [TICK_W-1:0]          o_tick_now,
    // configuration write port
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    t_period r_period [CHANNELS];
    t_mask   r_def_mask;
    logic    r_run;

    // ---------------------------------------------------------------
    // Scheduler state
    // ---------------------------------------------------------------
    t_tick   r_tick;
    t_tick   r_last [CHANNELS];
    logic    r_en   [CHANNELS];
    logic    r_pend [CHANNELS];

    t_tick   n_tick;
    t_tick   n_last [CHANNELS];
    logic    n_en   [CHANNELS];
    logic    n_pend [CHANNELS];

    // ---------------------------------------------------------------
    // Input register stage
    // ---------------------------------------------------------------
    logic              r_in_valid;
    logic [OP_W-1:0]   r_op;
    logic [CH_W-1:0]   r_channel;
    logic              r_enable_value;

    // ---------------------------------------------------------------
    // Result register stage
    // ---------------------------------------------------------------
    logic    r_out_valid;
    t_mask   r_fired;
    t_mask   r_served;
    t_tick   r_tick_now;

    t_mask   n_fired;
    t_mask   n_served;
    t_tick   gap [CHANNELS];
    logic    adv;       // result register may load this cycle
    logic    exec;      // a registered transaction is executed this cycle

    assign adv        = !r_out_valid || i_out_ready;
    assign exec       = adv && r_in_valid;
    assign o_in_ready = !r_in_valid || adv;

    assign o_out_valid     = r_out_valid;
    assign o_fired_mask    = r_fired;
    assign o_serviced_mask = r_served;
    assign o_tick_now      = r_tick_now;

    // Distance from each channel's last firing to the advanced tick; the
    // sign bit marks a last fire tick that lies ahead of the counter.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            gap[c] = r_tick + 1'b1 - r_last[c];
        end
    end

    // Single-pass update of all channels for the registered transaction
    always_comb begin
        n_tick   = r_tick;
        n_last   = r_last;
        n_en     = r_en;
        n_pend   = r_pend;
        n_fired  = '0;
        n_served = '0;
        unique case (t_op'(r_op))
            OP_TICK: begin
                // advance the counter even while stopped
                n_tick = r_tick + 1'b1;
                if (r_run) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (r_en[c] && !gap[c][TICK_W-1] &&
                            gap[c] >= TICK_W'(r_period[c])) begin
                            n_last[c] = r_tick + 1'b1;
                            n_pend[c] = (c < MASK_W) ? r_def_mask[c] : 1'b0;
                            if (c < MASK_W) begin
                                n_fired[c] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_SERVICE: begin
                // run and clear deferred work of enabled channels
                if (r_run) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (c < MASK_W) begin
                            if (r_en[c] && r_pend[c] && r_def_mask[c]) begin
                                n_pend[c]   = 1'b0;
                                n_served[c] = 1'b1;
                            end
                        end
                    end
                end
            end
            OP_SET_ENABLE: begin
                // pending flag is left as it is
                if (int'(r_channel) < CHANNELS) begin
                    n_en[r_channel]   = r_enable_value;
                    n_last[r_channel] = '0;
                end
            end
            default: begin
                // unused op code: hold all state, report empty masks
            end
        endcase
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_tick      <= '0;
            r_def_mask  <= '0;
            r_run       <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_last[c]   <= '0;
                r_en[c]     <= 1'b0;
                r_pend[c]   <= 1'b0;
                r_period[c] <= PERIOD_RESET;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
            if (exec) begin
                r_tick <= n_tick;
                r_last <= n_last;
                r_en   <= n_en;
                r_pend <= n_pend;
            end
            // configuration must be written only while the block is idle; the block does not enforce it
            if (i_cfg_we) begin
                for (int c = 0; c < PERIOD_REGS; c++) begin
                    if (c < CHANNELS && int'(i_cfg_index) == c) begin
                        r_period[c] <= i_cfg_wdata[PERIOD_W-1:0];
                    end
                end
                if (t_cfg_idx'(i_cfg_index) == CFG_DEFERRED) begin
                    r_def_mask <= i_cfg_wdata[MASK_W-1:0];
                end
                if (t_cfg_idx'(i_cfg_index) == CFG_RUN) begin
                    r_run <= i_cfg_wdata[0];
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_op           <= i_op;
            r_channel      <= i_channel;
            r_enable_value <= i_enable_value;
        end
        if (exec) begin
            r_fired    <= n_fired;
            r_served   <= n_served;
            r_tick_now <= n_tick;
        end
    end

endmodule

`default_nettype wire

[sv/pets_checker.sv]
// Port-level checker for the periodic event tick scheduler, with its bind.
// Depends on pets_pkg and the periodic_event_tick_scheduler top level.
`default_nettype none

module pets_checker
    import pets_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_in_ready,
    input wire logic              o_out_valid,
    input wire logic              i_out_ready,
    input wire logic [MASK_W-1:0] o_fired_mask,
    input wire logic [MASK_W-1:0] o_serviced_mask,
    input wire logic [TICK_W-1:0] o_tick_now
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_tick_now))
        else $error("result dropped or changed while stalled");

    // a transaction fires or services, never both
    a_one_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fired_mask == '0) || (o_serviced_mask == '0))
        else $error("fired and serviced masks both set");

    // with the result register empty the input side is never stalled
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty result register");

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind periodic_event_tick_scheduler pets_checker u_pets_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_fired_mask    (o_fired_mask),
    .o_serviced_mask (o_serviced_mask),
    .o_tick_now      (o_tick_now)
);

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for periodic_event_tick_scheduler: directed and random transactions,
// each result compared with a prediction of the channel scheduler kept in the bench.
// Depends on pets_pkg and the scheduler RTL; reads no files.

module tb_top;
    import pets_pkg::*;

    // Codes the package leaves unnamed: the spare op and the two unused register slots
    localparam logic [OP_W-1:0]      OP_UNUSED    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 80;
    localparam int STREAM_ITEMS  = 170;

    typedef struct packed {
        t_mask fired;
        t_mask serviced;
        t_tick tick_now;
    } t_sched_report;

    // ------------------------------------------------------------------
    // Clock, reset and the signals around the block
    // ------------------------------------------------------------------
    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_ready;
    logic [OP_W-1:0]       i_op           = OP_TICK;
    logic [CH_W-1:0]       i_channel      = '0;
    logic                  i_enable_value = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready    = 1'b0;
    t_mask                 o_fired_mask;
    t_mask                 o_serviced_mask;
    t_tick                 o_tick_now;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata    = '0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    periodic_event_tick_scheduler dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_op           (i_op),
        .i_channel      (i_channel),
        .i_enable_value (i_enable_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_fired_mask   (o_fired_mask),
        .o_serviced_mask(o_serviced_mask),
        .o_tick_now     (o_tick_now),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predicted scheduler: a copy of the registers and of the channel state
    // ------------------------------------------------------------------
    t_period period_q    [CHANNELS];
    t_mask   deferred_q;
    logic    run_q;
    t_tick   tick_q;
    t_tick   last_fire_q [CHANNELS];
    logic    chan_on_q   [CHANNELS];
    logic    pend_q      [CHANNELS];

    t_sched_report awaited_reports[$];
    t_sched_report want;

    bit          idle_on      = 1'b1;
    int unsigned mismatches   = 0;
    int unsigned items_sent   = 0;
    int unsigned results_seen = 0;
    int unsigned fire_ticks   = 0;
    int unsigned service_runs = 0;
    int unsigned tick_wraps   = 0;
    int unsigned quiet_cycles = 0;

    // Channels beyond the mask width never have a deferred half
    function automatic logic has_deferred(int c);
        return (c < MASK_W) && deferred_q[c];
    endfunction

    // Advance the predicted state by one transaction and return the report it yields
    function automatic t_sched_report schedule_step(logic [OP_W-1:0] op,
                                                    logic [CH_W-1:0] ch, logic en);
        t_sched_report r;
        t_tick         gap;
        r = '0;
        case (op)
            OP_TICK: begin
                // The counter moves even while stopped; only firing is gated
                tick_q = tick_q + 1'b1;
                if (tick_q == '0)
                    tick_wraps++;
                if (run_q) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        gap = tick_q - last_fire_q[c];
                        // A negative signed distance never fires, whatever the period
                        if (chan_on_q[c] && !gap[TICK_W-1] && gap >= TICK_W'(period_q[c])) begin
                            last_fire_q[c] = tick_q;
                            pend_q[c]      = has_deferred(c);
                            if (c < MASK_W)
                                r.fired[c] = 1'b1;
                        end
                    end
                end
            end
            OP_SERVICE: begin
                if (run_q) begin
                    for (int c = 0; c < CHANNELS; c++) begin
                        if (chan_on_q[c] && pend_q[c] && has_deferred(c)) begin
                            pend_q[c]     = 1'b0;
                            r.serviced[c] = 1'b1;
                        end
                    end
                end
            end
            OP_SET_ENABLE: begin
                // The pending flag survives an enable change
                if (ch < CHANNELS) begin
                    chan_on_q[ch]   = en;
                    last_fire_q[ch] = '0;
                end
            end
            default: ;
        endcase
        r.tick_now = tick_q;
        if (r.fired != '0)
            fire_ticks++;
        if (r.serviced != '0)
            service_runs++;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Present one transaction, hold it until accepted, then log its expected report
    task automatic send_item(logic [OP_W-1:0] op, logic [CH_W-1:0] ch, logic en);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_op           <= op;
        i_channel      <= ch;
        i_enable_value <= en;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        awaited_reports.push_back(schedule_step(op, ch, en));
        items_sent++;
    endtask

    // Drop valid and wait until every outstanding report has been checked
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (awaited_reports.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register write; only called with the block idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx < PERIOD_REGS && idx < CHANNELS)
            period_q[idx] = data[PERIOD_W-1:0];
        else if (idx == CFG_DEFERRED)
            deferred_q = data[MASK_W-1:0];
        else if (idx == CFG_RUN)
            run_q = data[0];
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Result side: random back-pressure and the report checker
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    end

    task automatic flag_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (awaited_reports.size() == 0) begin
                flag_mismatch("unexpected result, tick_now", '0, 32'(o_tick_now));
            end else begin
                want = awaited_reports.pop_front();
                if (o_fired_mask !== want.fired)
                    flag_mismatch("fired_mask", 32'(want.fired), 32'(o_fired_mask));
                if (o_serviced_mask !== want.serviced)
                    flag_mismatch("serviced_mask", 32'(want.serviced), 32'(o_serviced_mask));
                if (o_tick_now !== want.tick_now)
                    flag_mismatch("tick_now", 32'(want.tick_now), 32'(o_tick_now));
            end
        end
    end

    // Watchdog: end the run if no transaction moves on any port for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: the block is stopped, so ticks only count and service reports nothing
    task automatic test_stopped_block();
        send_item(OP_TICK, 2'd3, 1'b1);
        for (int c = 0; c < CHANNELS; c++)
            send_item(OP_SET_ENABLE, CH_W'(c), 1'b1);
        send_item(OP_TICK, 2'd0, 1'b0);
        send_item(OP_SERVICE, 2'd0, 1'b0);
        send_item(OP_UNUSED, 2'd3, 1'b1);
    endtask

    // Running with the shortest, zero and longest periods and a mixed deferred mask
    task automatic test_first_firings();
        drain_results();
        write_reg(CFG_PERIOD_CH0, 15'd1);
        write_reg(CFG_PERIOD_CH1, 15'd2);
        write_reg(CFG_PERIOD_CH2, 15'd0);
        write_reg(CFG_PERIOD_CH3, 15'h7FFF);
        write_reg(CFG_DEFERRED, 15'h7FF5);
        write_reg(CFG_RUN, 15'h7FFF);
        write_reg(CFG_SPARE_LO, 15'h7FFF);
        write_reg(CFG_SPARE_HI, 15'h2AAA);
        send_item(OP_TICK, 2'd0, 1'b0);
        send_item(OP_TICK, 2'd0, 1'b0);
        send_item(OP_SERVICE, 2'd0, 1'b0);
        // nothing left to service
        send_item(OP_SERVICE, 2'd0, 1'b0);
        send_item(OP_TICK, 2'd0, 1'b0);
        // disabled channel keeps its pending work but is not serviced
        send_item(OP_SET_ENABLE, 2'd0, 1'b0);
        send_item(OP_SERVICE, 2'd0, 1'b0);
        send_item(OP_SET_ENABLE, 2'd0, 1'b1);
        send_item(OP_SERVICE, 2'd0, 1'b0);
        send_item(OP_TICK, 2'd1, 1'b1);
        send_item(OP_TICK, 2'd2, 1'b0);
        send_item(OP_UNUSED, 2'd0, 1'b0);
        send_item(OP_SET_ENABLE, 2'd3, 1'b0);
        send_item(OP_TICK, 2'd3, 1'b1);
    endtask

    // Phases of random transactions, each under fresh random register settings
    task automatic test_random_phases();
        int unsigned           sel;
        logic [OP_W-1:0]       op;
        logic [CFG_DATA_W-1:0] data;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            for (int c = 0; c < PERIOD_REGS; c++) begin
                // mostly short periods so channels fire often; extremes now and then
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    data = '0;
                else if (sel == 1)
                    data = '1;
                else if (sel == 2)
                    data = CFG_DATA_W'($urandom);
                else
                    data = CFG_DATA_W'($urandom_range(1, 12));
                write_reg(CFG_IDX_W'(c), data);
            end
            write_reg(CFG_DEFERRED, CFG_DATA_W'($urandom));
            data    = CFG_DATA_W'($urandom);
            data[0] = ($urandom_range(0, 4) != 0);
            write_reg(CFG_RUN, data);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                          CFG_DATA_W'($urandom));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 60)
                    op = OP_TICK;
                else if (sel < 78)
                    op = OP_SERVICE;
                else if (sel < 95)
                    op = OP_SET_ENABLE;
                else
                    op = OP_UNUSED;
                send_item(op, CH_W'($urandom), $urandom_range(0, 3) != 0);
            end
        end
    endtask

    // Closing stream without idling: ticks back to back at full rate on both sides,
    // with an occasional service or enable change
    task automatic test_tick_stream();
        int unsigned     sel;
        logic [OP_W-1:0] op;
        drain_results();
        write_reg(CFG_PERIOD_CH0, 15'h7FFF);
        write_reg(CFG_PERIOD_CH1, 15'd3);
        write_reg(CFG_PERIOD_CH2, 15'd0);
        write_reg(CFG_PERIOD_CH3, 15'd1);
        write_reg(CFG_DEFERRED, 15'h000F);
        write_reg(CFG_RUN, 15'h0001);
        idle_on = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
            send_item(OP_SET_ENABLE, CH_W'(c), 1'b1);
        for (int n = 0; n < STREAM_ITEMS; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 96)
                op = OP_TICK;
            else if (sel < 98)
                op = OP_SERVICE;
            else
                op = OP_SET_ENABLE;
            send_item(op, CH_W'($urandom), $urandom_range(0, 7) != 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        for (int c = 0; c < CHANNELS; c++) begin
            period_q[c]    = PERIOD_RESET;
            last_fire_q[c] = '0;
            chan_on_q[c]   = 1'b0;
            pend_q[c]      = 1'b0;
        end
        deferred_q = '0;
        run_q      = 1'b0;
        tick_q     = '0;

        // hold reset, then release it for good
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_stopped_block();
        test_first_firings();
        test_random_phases();
        test_tick_stream();

        drain_results();
        repeat (10) @(posedge i_clk);

        $display("Run covered %0d transactions and %0d checked results.",
                 items_sent, results_seen);
        $display("%0d ticks fired a channel, %0d services ran deferred work, counter wrapped %0d.",
                 fire_ticks, service_runs, tick_wraps);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
sv/pets_pkg.sv
sv/periodic_event_tick_scheduler.sv
sv/pets_checker.sv
tb/tb_top.sv
